### design/sac_pkg.sv
`timescale 1ns / 1ps
package sac_pkg;

	localparam int DEF_LINE_BYTES = 32;
	localparam int DEF_NUM_WAYS   = 4;
	localparam int DEF_NUM_SETS   = 64;

	localparam int ADDR_W = 32;
	localparam int DATA_W = 32;
	localparam int AGE_W  = 8;
	localparam logic [AGE_W-1:0] AGE_MAX = '1;

	localparam logic [1:0] OP_READ  = 2'd0;
	localparam logic [1:0] OP_WRITE = 2'd1;
	localparam logic [1:0] OP_FILL  = 2'd2;

	typedef enum logic [2:0] {
		KIND_READ    = 3'd0,
		KIND_WRITE   = 3'd1,
		KIND_WB      = 3'd2,
		KIND_FILLREQ = 3'd3,
		KIND_REJECT  = 3'd4
	} kind_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DISPATCH,
		ST_DECIDE,
		ST_HIT_OUT,
		ST_WB_RD,
		ST_WB_OUT,
		ST_FREQ,
		ST_FILL_FIN,
		ST_FILL_OUT
	} state_t;

	typedef enum logic [2:0] {
		SEL_REJECT,
		SEL_HIT_WR,
		SEL_HIT_RD,
		SEL_WB,
		SEL_FREQ,
		SEL_FILL_WR,
		SEL_FILL_RD
	} out_sel_t;

	typedef struct packed {
		logic     take;
		logic     fill_word;
		logic     capture;
		logic     hit_commit;
		logic     hit_wr_data;
		logic     hit_rd;
		logic     miss_commit;
		logic     wb_rd;
		logic     wb_adv;
		logic     fill_fin;
		logic     fill_wr_data;
		logic     fill_rd;
		logic     out_load;
		out_sel_t out_sel;
	} cmd_t;

	typedef struct packed {
		logic req_reject;
		logic req_fill;
		logic req_write;
		logic fill_last;
		logic hit;
		logic victim_dirty;
		logic wb_last;
		logic pend_write;
		logic out_free;
	} status_t;

endpackage

### design/sac_if.sv
`timescale 1ns / 1ps
interface sac_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  opcode;
	logic [31:0] address;
	logic [31:0] word_in;
	modport source (output valid, opcode, address, word_in, input ready);
	modport sink (input valid, opcode, address, word_in, output ready);
endinterface

interface sac_rsp_if;
	logic        valid;
	logic        ready;
	logic [2:0]  kind;
	logic [31:0] mem_address;
	logic [31:0] word_out;
	logic        was_hit;
	logic        last;
	modport source (output valid, kind, mem_address, word_out, was_hit, last, input ready);
	modport sink (input valid, kind, mem_address, word_out, was_hit, last, output ready);
endinterface

### design/sac_ram.sv
`timescale 1ns / 1ps
module sac_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

### design/sac_ctrl.sv
`timescale 1ns / 1ps
module sac_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             req_valid,
	output logic             req_ready,
	input  sac_pkg::status_t st,
	output sac_pkg::cmd_t    cmd
);
	import sac_pkg::*;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		cmd         = '0;
		cmd.out_sel = SEL_REJECT;
		req_ready   = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					cmd.take = 1'b1;
					state_d  = ST_DISPATCH;
				end
			end
			ST_DISPATCH: begin
				priority if (st.req_reject) begin
					if (st.out_free) begin
						cmd.out_load = 1'b1;
						cmd.out_sel  = SEL_REJECT;
						state_d      = ST_IDLE;
					end
				end else if (st.req_fill) begin
					cmd.fill_word = 1'b1;
					state_d       = st.fill_last ? ST_FILL_FIN : ST_IDLE;
				end else begin
					cmd.capture = 1'b1;
					state_d     = ST_DECIDE;
				end
			end
			ST_DECIDE: begin
				priority if (st.hit && st.req_write) begin
					if (st.out_free) begin
						cmd.hit_commit  = 1'b1;
						cmd.hit_wr_data = 1'b1;
						cmd.out_load    = 1'b1;
						cmd.out_sel     = SEL_HIT_WR;
						state_d         = ST_IDLE;
					end
				end else if (st.hit) begin
					cmd.hit_commit = 1'b1;
					cmd.hit_rd     = 1'b1;
					state_d        = ST_HIT_OUT;
				end else begin
					cmd.miss_commit = 1'b1;
					state_d         = st.victim_dirty ? ST_WB_RD : ST_FREQ;
				end
			end
			ST_HIT_OUT: begin
				if (st.out_free) begin
					cmd.out_load = 1'b1;
					cmd.out_sel  = SEL_HIT_RD;
					state_d      = ST_IDLE;
				end
			end
			ST_WB_RD: begin
				cmd.wb_rd = 1'b1;
				state_d   = ST_WB_OUT;
			end
			ST_WB_OUT: begin
				if (st.out_free) begin
					cmd.out_load = 1'b1;
					cmd.out_sel  = SEL_WB;
					cmd.wb_adv   = 1'b1;
					state_d      = st.wb_last ? ST_FREQ : ST_WB_RD;
				end
			end
			ST_FREQ: begin
				if (st.out_free) begin
					cmd.out_load = 1'b1;
					cmd.out_sel  = SEL_FREQ;
					state_d      = ST_IDLE;
				end
			end
			ST_FILL_FIN: begin
				priority if (st.pend_write) begin
					if (st.out_free) begin
						cmd.fill_fin     = 1'b1;
						cmd.fill_wr_data = 1'b1;
						cmd.out_load     = 1'b1;
						cmd.out_sel      = SEL_FILL_WR;
						state_d          = ST_IDLE;
					end
				end else begin
					cmd.fill_fin = 1'b1;
					cmd.fill_rd  = 1'b1;
					state_d      = ST_FILL_OUT;
				end
			end
			ST_FILL_OUT: begin
				if (st.out_free) begin
					cmd.out_load = 1'b1;
					cmd.out_sel  = SEL_FILL_RD;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	ap_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		req_ready |-> state_q == ST_IDLE)
		else $error("ready outside idle");
	ap_take_dispatch: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.take |=> state_q == ST_DISPATCH)
		else $error("accepted word not dispatched");
	ap_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> st.out_free)
		else $error("result register overwritten");
endmodule

### design/sac_dp.sv
`timescale 1ns / 1ps
module sac_dp #(
	parameter int LINE_BYTES = sac_pkg::DEF_LINE_BYTES,
	parameter int NUM_WAYS   = sac_pkg::DEF_NUM_WAYS,
	parameter int NUM_SETS   = sac_pkg::DEF_NUM_SETS
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [1:0]       req_opcode,
	input  logic [31:0]      req_address,
	input  logic [31:0]      req_word,
	input  sac_pkg::cmd_t    cmd,
	output sac_pkg::status_t st,
	output logic             rsp_valid,
	input  logic             rsp_ready,
	output logic [2:0]       rsp_kind,
	output logic [31:0]      rsp_mem_address,
	output logic [31:0]      rsp_word_out,
	output logic             rsp_was_hit,
	output logic             rsp_last
);
	import sac_pkg::*;

	localparam int WORDS     = LINE_BYTES / 4;
	localparam int OFF_BITS  = $clog2(LINE_BYTES);
	localparam int SET_BITS  = $clog2(NUM_SETS);
	localparam int WORD_BITS = $clog2(WORDS);
	localparam int WAY_BITS  = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1;
	localparam int TAG_BITS  = ADDR_W - OFF_BITS - SET_BITS;
	localparam int META_W    = TAG_BITS + 1 + AGE_W;
	localparam int DADDR_W   = SET_BITS + WAY_BITS + WORD_BITS;
	localparam logic [WORD_BITS-1:0] LAST_WORD = WORD_BITS'(WORDS - 1);

	// request and pending-miss registers
	logic [1:0]           req_op_q;
	logic [ADDR_W-1:0]    req_addr_q;
	logic [DATA_W-1:0]    req_word_q;
	logic                 pend_q;
	logic                 pend_write_q;
	logic [ADDR_W-1:0]    pend_addr_q;
	logic [DATA_W-1:0]    pend_word_q;
	logic [WAY_BITS-1:0]  pend_way_q;
	logic [WORD_BITS-1:0] fill_cnt_q;
	logic [WORD_BITS-1:0] wb_cnt_q;
	logic [WAY_BITS-1:0]  vic_q;
	logic [TAG_BITS-1:0]  vic_tag_q;
	logic                 hit_q;
	logic [WAY_BITS-1:0]  hit_way_q;
	logic [AGE_W-1:0]     age_q [NUM_WAYS];
	logic [NUM_SETS-1:0][NUM_WAYS-1:0] valid_q;

	logic [SET_BITS-1:0]  set_r, pset;
	logic [TAG_BITS-1:0]  tag_r, ptag;
	logic [WORD_BITS-1:0] wi_r, pwi;
	logic [NUM_WAYS-1:0]  vrow;

	assign set_r = req_addr_q[OFF_BITS +: SET_BITS];
	assign tag_r = req_addr_q[ADDR_W-1 -: TAG_BITS];
	assign wi_r  = req_addr_q[2 +: WORD_BITS];
	assign pset  = pend_addr_q[OFF_BITS +: SET_BITS];
	assign ptag  = pend_addr_q[ADDR_W-1 -: TAG_BITS];
	assign pwi   = pend_addr_q[2 +: WORD_BITS];
	assign vrow  = valid_q[set_r];

	// metadata: one RAM per way, tag/dirty/age by set
	logic [META_W-1:0]   meta_rd [NUM_WAYS];
	logic [META_W-1:0]   meta_wd [NUM_WAYS];
	logic [NUM_WAYS-1:0] meta_we;
	logic [SET_BITS-1:0] meta_waddr;

	for (genvar g = 0; g < NUM_WAYS; g++) begin : g_meta
		sac_ram #(.WIDTH(META_W), .DEPTH(NUM_SETS)) u_meta (
			.clk   (clk),
			.we    (meta_we[g]),
			.waddr (meta_waddr),
			.wdata (meta_wd[g]),
			.re    (cmd.take),
			.raddr (req_address[OFF_BITS +: SET_BITS]),
			.rdata (meta_rd[g])
		);
	end

	// lookup: first matching way, aged counters
	logic                hit_c;
	logic [WAY_BITS-1:0] hit_way_c;
	logic [AGE_W-1:0]    aged_c [NUM_WAYS];

	always_comb begin
		hit_c     = 1'b0;
		hit_way_c = '0;
		for (int w = NUM_WAYS - 1; w >= 0; w--) begin
			if (vrow[w] && meta_rd[w][META_W-1 -: TAG_BITS] == tag_r) begin
				hit_c     = 1'b1;
				hit_way_c = WAY_BITS'(w);
			end
		end
		for (int w = 0; w < NUM_WAYS; w++) begin
			aged_c[w] = meta_rd[w][AGE_W-1:0];
			if (vrow[w] && aged_c[w] != AGE_MAX) begin
				aged_c[w] = aged_c[w] + AGE_W'(1);
			end
		end
	end

	// victim: first invalid way, else lowest way of highest age
	logic [WAY_BITS-1:0] vic_c, vic_old, vic_inv;
	logic                any_inv;
	logic [AGE_W-1:0]    best;

	always_comb begin
		vic_old = '0;
		best    = '0;
		vic_inv = '0;
		any_inv = 1'b0;
		for (int w = 0; w < NUM_WAYS; w++) begin
			if (age_q[w] > best) begin
				best    = age_q[w];
				vic_old = WAY_BITS'(w);
			end
		end
		for (int w = NUM_WAYS - 1; w >= 0; w--) begin
			if (!vrow[w]) begin
				any_inv = 1'b1;
				vic_inv = WAY_BITS'(w);
			end
		end
		vic_c = any_inv ? vic_inv : vic_old;
	end

	always_comb begin
		meta_waddr = cmd.fill_fin ? pset : set_r;
		for (int w = 0; w < NUM_WAYS; w++) begin
			meta_we[w] = cmd.hit_commit || cmd.miss_commit ||
				(cmd.fill_fin && pend_way_q == WAY_BITS'(w));
			meta_wd[w] = {meta_rd[w][META_W-1 -: TAG_BITS], meta_rd[w][AGE_W], age_q[w]};
			if (cmd.hit_commit && hit_way_q == WAY_BITS'(w)) begin
				meta_wd[w] = {meta_rd[w][META_W-1 -: TAG_BITS],
					meta_rd[w][AGE_W] | (req_op_q == OP_WRITE), {AGE_W{1'b0}}};
			end
			if (cmd.fill_fin) begin
				meta_wd[w] = {ptag, pend_write_q, {AGE_W{1'b0}}};
			end
		end
	end

	// line data
	logic                dat_we, dat_re;
	logic [DADDR_W-1:0]  dat_waddr, dat_raddr;
	logic [DATA_W-1:0]   dat_wd, dat_rd;

	always_comb begin
		dat_we    = cmd.fill_word || cmd.hit_wr_data || cmd.fill_wr_data;
		dat_waddr = {pset, pend_way_q, fill_cnt_q};
		dat_wd    = req_word_q;
		priority if (cmd.hit_wr_data) begin
			dat_waddr = {set_r, hit_way_q, wi_r};
		end else if (cmd.fill_wr_data) begin
			dat_waddr = {pset, pend_way_q, pwi};
			dat_wd    = pend_word_q;
		end else begin
			dat_waddr = {pset, pend_way_q, fill_cnt_q};
		end
		dat_re    = cmd.hit_rd || cmd.wb_rd || cmd.fill_rd;
		priority if (cmd.hit_rd) begin
			dat_raddr = {set_r, hit_way_q, wi_r};
		end else if (cmd.wb_rd) begin
			dat_raddr = {set_r, vic_q, wb_cnt_q};
		end else begin
			dat_raddr = {pset, pend_way_q, pwi};
		end
	end

	sac_ram #(.WIDTH(DATA_W), .DEPTH(2 ** DADDR_W)) u_data (
		.clk   (clk),
		.we    (dat_we),
		.waddr (dat_waddr),
		.wdata (dat_wd),
		.re    (dat_re),
		.raddr (dat_raddr),
		.rdata (dat_rd)
	);

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.take) begin
			req_op_q   <= req_opcode;
			req_addr_q <= req_address;
			req_word_q <= req_word;
		end
		if (cmd.capture) begin
			hit_q     <= hit_c;
			hit_way_q <= hit_way_c;
			age_q     <= aged_c;
		end
		if (cmd.miss_commit) begin
			pend_write_q <= (req_op_q == OP_WRITE);
			pend_addr_q  <= req_addr_q;
			pend_word_q  <= req_word_q;
			pend_way_q   <= vic_c;
			vic_q        <= vic_c;
			vic_tag_q    <= meta_rd[vic_c][META_W-1 -: TAG_BITS];
			wb_cnt_q     <= '0;
		end else if (cmd.wb_adv) begin
			wb_cnt_q <= wb_cnt_q + WORD_BITS'(1);
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q     <= 1'b0;
			fill_cnt_q <= '0;
			valid_q    <= '0;
		end else begin
			if (cmd.miss_commit) begin
				pend_q            <= 1'b1;
				fill_cnt_q        <= '0;
				valid_q[set_r][vic_c] <= 1'b0;
			end
			if (cmd.fill_word) begin
				fill_cnt_q <= fill_cnt_q + WORD_BITS'(1);
			end
			if (cmd.fill_fin) begin
				pend_q                     <= 1'b0;
				valid_q[pset][pend_way_q] <= 1'b1;
			end
		end
	end

	// result register
	logic              out_valid_q;
	logic [2:0]        out_kind_q;
	logic [ADDR_W-1:0] out_addr_q;
	logic [DATA_W-1:0] out_word_q;
	logic              out_hit_q, out_last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_word_q <= '0;
			out_hit_q  <= 1'b0;
			out_last_q <= 1'b1;
			out_addr_q <= req_addr_q;
			unique case (cmd.out_sel)
				SEL_REJECT: out_kind_q <= KIND_REJECT;
				SEL_HIT_WR: begin
					out_kind_q <= KIND_WRITE;
					out_hit_q  <= 1'b1;
				end
				SEL_HIT_RD: begin
					out_kind_q <= KIND_READ;
					out_hit_q  <= 1'b1;
					out_word_q <= dat_rd;
				end
				SEL_WB: begin
					out_kind_q <= KIND_WB;
					out_addr_q <= {vic_tag_q, set_r, wb_cnt_q, 2'b00};
					out_word_q <= dat_rd;
					out_last_q <= 1'b0;
				end
				SEL_FREQ: begin
					out_kind_q <= KIND_FILLREQ;
					out_addr_q <= {req_addr_q[ADDR_W-1:OFF_BITS], {OFF_BITS{1'b0}}};
				end
				SEL_FILL_WR: begin
					out_kind_q <= KIND_WRITE;
					out_addr_q <= pend_addr_q;
				end
				SEL_FILL_RD: begin
					out_kind_q <= KIND_READ;
					out_addr_q <= pend_addr_q;
					out_word_q <= dat_rd;
				end
				default: out_kind_q <= KIND_REJECT;
			endcase
		end
	end

	assign rsp_valid       = out_valid_q;
	assign rsp_kind        = out_kind_q;
	assign rsp_mem_address = out_addr_q;
	assign rsp_word_out    = out_word_q;
	assign rsp_was_hit     = out_hit_q;
	assign rsp_last        = out_last_q;

	// status to the controller
	always_comb begin
		st.req_fill     = (req_op_q == OP_FILL);
		st.req_write    = (req_op_q == OP_WRITE);
		st.req_reject   = st.req_fill ? !pend_q
			: (pend_q || (req_op_q != OP_READ && req_op_q != OP_WRITE));
		st.fill_last    = (fill_cnt_q == LAST_WORD);
		st.hit          = hit_q;
		st.victim_dirty = vrow[vic_c] && meta_rd[vic_c][AGE_W];
		st.wb_last      = (wb_cnt_q == LAST_WORD);
		st.pend_write   = pend_write_q;
		st.out_free     = !out_valid_q || rsp_ready;
	end

	ap_fill_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		fill_cnt_q != '0 |-> pend_q)
		else $error("fill count without pending miss");
	ap_pend_line: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q |-> !valid_q[pset][pend_way_q])
		else $error("pending line marked valid");
	ap_fin_clears: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.fill_fin |=> !pend_q)
		else $error("fill completion left miss pending");
endmodule

### design/set_assoc_writeback_cache.sv
// Set-associative write-back cache, one word per handshake on each side.
// Path from accept to result register: a reject is loaded from dispatch, a write hit from
// decide, a read hit after its line RAM read; a miss first writes back each word of a dirty
// victim, then loads the fill request; the last fill word loads a write or read result;
// non-last fill words give no result. A busy result register adds its wait.
// One word in flight: the next is accepted once the controller is back in idle.
// Asynchronous reset clears the valid bits, pending miss and result register.
`timescale 1ns / 1ps
module set_assoc_writeback_cache #(
	parameter int LINE_BYTES = sac_pkg::DEF_LINE_BYTES,
	parameter int NUM_WAYS   = sac_pkg::DEF_NUM_WAYS,
	parameter int NUM_SETS   = sac_pkg::DEF_NUM_SETS
) (
	input logic  clk,
	input logic  arst_n,
	sac_req_if.sink   req,
	sac_rsp_if.source rsp
);
	import sac_pkg::*;

	cmd_t    cmd;
	status_t st;

	// controller: sequences lookup, writeback, fill and result hand-off
	sac_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.st        (st),
		.cmd       (cmd)
	);

	// datapath: tag/age RAMs per way, line RAM, pending miss, result register
	sac_dp #(
		.LINE_BYTES (LINE_BYTES),
		.NUM_WAYS   (NUM_WAYS),
		.NUM_SETS   (NUM_SETS)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.req_opcode      (req.opcode),
		.req_address     (req.address),
		.req_word        (req.word_in),
		.cmd             (cmd),
		.st              (st),
		.rsp_valid       (rsp.valid),
		.rsp_ready       (rsp.ready),
		.rsp_kind        (rsp.kind),
		.rsp_mem_address (rsp.mem_address),
		.rsp_word_out    (rsp.word_out),
		.rsp_was_hit     (rsp.was_hit),
		.rsp_last        (rsp.last)
	);
endmodule
